// ----- rtl/reservation_station_select_macros.svh -----
// Assertion macros shared by the checker of the reservation station.
`ifndef RESERVATION_STATION_SELECT_MACROS_SVH
`define RESERVATION_STATION_SELECT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("reservation station check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define RSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("reservation station check failed one cycle later");

`endif

// ----- rtl/rss_pkg.sv -----
// Shared constants, codes and controller/datapath interface types.
package rss_pkg;

  localparam int RSS_ENTRIES  = 16;
  localparam int RSS_TAG_BITS = 8;

  localparam int SEQ_W      = 32;
  localparam int PORT_TAG_W = 8;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WAKEUP   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SELECT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SCHEDULE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ISSUE_MODE     = 2'd1;

  localparam logic [CFG_DATA_W-1:0] ENTRIES_IN_USE_RST = 5'd16;
  localparam logic                  ISSUE_MODE_RST     = 1'b1;

  typedef struct packed {
    logic load;   // capture a new item and restart the walk
    logic step;   // examine the entry under the walk pointer
    logic emit;   // register the result for the output strobe
  } rss_cmd_t;

  typedef struct packed {
    logic scan_done;  // the current item needs no further walk cycles
  } rss_sts_t;

endpackage

// ----- rtl/rss_ctrl.sv -----
// Controller state machine that sequences item capture, entry walk and result.
module rss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output rss_pkg::rss_cmd_t cmd,
  input  rss_pkg::rss_sts_t sts
);
  import rss_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy     = busy_r;
  assign cmd.load = start && !busy_r;
  assign cmd.step = (state_r == ST_SCAN);
  assign cmd.emit = (state_r == ST_RESP);

endmodule

// ----- rtl/rss_dp.sv -----
// Datapath: entry table, configuration registers, walk pointer and result registers.
module rss_dp #(
  parameter int ENTRIES  = rss_pkg::RSS_ENTRIES,
  parameter int TAG_BITS = rss_pkg::RSS_TAG_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rss_pkg::rss_cmd_t                cmd,
  output rss_pkg::rss_sts_t                sts,
  input  logic [rss_pkg::KIND_W-1:0]       in_kind,
  input  logic [rss_pkg::SEQ_W-1:0]        in_seq_number,
  input  logic [rss_pkg::PORT_TAG_W-1:0]   in_first_tag,
  input  logic                             in_first_ready,
  input  logic [rss_pkg::PORT_TAG_W-1:0]   in_second_tag,
  input  logic                             in_second_ready,
  input  logic [rss_pkg::PORT_TAG_W-1:0]   in_broadcast_tag,
  input  logic                             cfg_we,
  input  logic [rss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             out_strobe,
  output logic                             out_space_available,
  output logic                             out_insert_dropped,
  output logic                             out_found,
  output logic [rss_pkg::SEQ_W-1:0]        out_picked_number,
  output logic [rss_pkg::PORT_TAG_W-1:0]   out_picked_first_tag,
  output logic [rss_pkg::PORT_TAG_W-1:0]   out_picked_second_tag
);
  import rss_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CW    = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;

  // Configuration.
  logic [CFG_DATA_W-1:0] entries_r;
  logic                  mode_r;

  // Captured item.
  logic [KIND_W-1:0]   kind_r;
  logic [SEQ_W-1:0]    seq_r;
  logic [TAG_BITS-1:0] t1_r;
  logic                r1_r;
  logic [TAG_BITS-1:0] t2_r;
  logic                r2_r;
  logic [TAG_BITS-1:0] bt_r;

  // Entry table.
  logic [ENTRIES-1:0]  valid_r;
  logic [ENTRIES-1:0]  sched_r;
  logic [SEQ_W-1:0]    num_r  [ENTRIES];
  logic [TAG_BITS-1:0] tag1_r [ENTRIES];
  logic [ENTRIES-1:0]  rdy1_r;
  logic [TAG_BITS-1:0] tag2_r [ENTRIES];
  logic [ENTRIES-1:0]  rdy2_r;

  // Walk state.
  logic [IDX_W-1:0]    idx_r;
  logic                best_vld_r;
  logic                best_both_r;
  logic [SEQ_W-1:0]    best_num_r;
  logic [TAG_BITS-1:0] best_t1_r;
  logic [TAG_BITS-1:0] best_t2_r;
  logic                dropped_r;

  // Result registers.
  logic                  out_strobe_r;
  logic                  out_space_r;
  logic                  out_dropped_r;
  logic                  out_found_r;
  logic [SEQ_W-1:0]      out_num_r;
  logic [PORT_TAG_W-1:0] out_t1_r;
  logic [PORT_TAG_W-1:0] out_t2_r;

  logic [CW-1:0]      req_cnt;
  logic [CNT_W-1:0]   n_eff;
  logic               n_zero;
  logic [ENTRIES-1:0] in_use;
  logic               space;
  logic               cur_valid;
  logic               cur_sched;
  logic               cur_both;
  logic [SEQ_W-1:0]   cur_num;
  logic               walk;
  logic               hit;
  logic               cand;
  logic               last;
  logic               take;
  logic               sel_found;

  // An oversized count acts as the full table.
  assign req_cnt = CW'(entries_r);
  assign n_eff   = (req_cnt > CW'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(req_cnt);
  assign n_zero  = (n_eff == '0);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      in_use[i] = (CNT_W'(i) < n_eff);
    end
  end

  assign space = |(in_use & ~valid_r);

  assign cur_valid = valid_r[idx_r];
  assign cur_sched = sched_r[idx_r];
  assign cur_both  = rdy1_r[idx_r] && rdy2_r[idx_r];
  assign cur_num   = num_r[idx_r];
  assign last      = ((CNT_W'(idx_r) + CNT_W'(1)) == n_eff);

  always_comb begin
    walk = 1'b0;
    hit  = 1'b0;
    cand = 1'b0;
    unique case (kind_r)
      KIND_INSERT: begin
        walk = 1'b1;
        hit  = !cur_valid;
      end
      KIND_SCHEDULE: begin
        walk = 1'b1;
        hit  = cur_valid && (cur_num == seq_r);
      end
      KIND_REMOVE: begin
        walk = 1'b1;
        hit  = cur_valid && cur_sched && (cur_num == seq_r);
      end
      KIND_SELECT: begin
        walk = 1'b1;
        cand = cur_valid && !cur_sched && (!mode_r || cur_both);
      end
      default: begin
        walk = 1'b0;
      end
    endcase
    hit  = hit && !n_zero;
    cand = cand && !n_zero;
  end

  // Strict less-than keeps the lowest index among equal numbers.
  assign take = cand && (!best_vld_r || (cur_num < best_num_r));
  assign sts.scan_done = !walk || n_zero || hit || last;

  // In-order mode reports the oldest entry only when both sources are ready.
  assign sel_found = (kind_r == KIND_SELECT) && best_vld_r && (mode_r || best_both_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r    <= ENTRIES_IN_USE_RST;
      mode_r       <= ISSUE_MODE_RST;
      valid_r      <= '0;
      sched_r      <= '0;
      best_vld_r   <= 1'b0;
      dropped_r    <= 1'b0;
      idx_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENTRIES_IN_USE: entries_r <= cfg_data;
          CFG_ISSUE_MODE:     mode_r    <= cfg_data[0];
          default: begin
          end
        endcase
      end
      out_strobe_r <= cmd.emit;
      if (cmd.load) begin
        idx_r      <= '0;
        best_vld_r <= 1'b0;
        dropped_r  <= 1'b0;
      end else if (cmd.step) begin
        idx_r <= IDX_W'(idx_r + IDX_W'(1));
        if (take) begin
          best_vld_r <= 1'b1;
        end
        if (kind_r == KIND_INSERT && !hit && sts.scan_done) begin
          dropped_r <= 1'b1;
        end
        if (hit) begin
          unique case (kind_r)
            KIND_INSERT: begin
              valid_r[idx_r] <= 1'b1;
              sched_r[idx_r] <= 1'b0;
            end
            KIND_SCHEDULE: begin
              sched_r[idx_r] <= 1'b1;
            end
            KIND_REMOVE: begin
              valid_r[idx_r] <= 1'b0;
              sched_r[idx_r] <= 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      seq_r  <= in_seq_number;
      t1_r   <= TAG_BITS'(in_first_tag);
      r1_r   <= in_first_ready;
      t2_r   <= TAG_BITS'(in_second_tag);
      r2_r   <= in_second_ready;
      bt_r   <= TAG_BITS'(in_broadcast_tag);
    end
    if (cmd.step && take) begin
      best_both_r <= cur_both;
      best_num_r  <= cur_num;
      best_t1_r   <= tag1_r[idx_r];
      best_t2_r   <= tag2_r[idx_r];
    end
    if (cmd.step && hit && kind_r == KIND_INSERT) begin
      num_r[idx_r]  <= seq_r;
      tag1_r[idx_r] <= t1_r;
      rdy1_r[idx_r] <= r1_r;
      tag2_r[idx_r] <= t2_r;
      rdy2_r[idx_r] <= r2_r;
    end
    // Wakeup compares every entry in use at once.
    if (cmd.step && kind_r == KIND_WAKEUP) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (in_use[i] && valid_r[i]) begin
          if (tag1_r[i] == bt_r) begin
            rdy1_r[i] <= 1'b1;
          end
          if (tag2_r[i] == bt_r) begin
            rdy2_r[i] <= 1'b1;
          end
        end
      end
    end
    if (cmd.emit) begin
      out_space_r   <= space;
      out_dropped_r <= dropped_r;
      out_found_r   <= sel_found;
      out_num_r     <= sel_found ? best_num_r : '0;
      out_t1_r      <= sel_found ? PORT_TAG_W'(best_t1_r) : '0;
      out_t2_r      <= sel_found ? PORT_TAG_W'(best_t2_r) : '0;
    end
  end

  assign out_strobe            = out_strobe_r;
  assign out_space_available   = out_space_r;
  assign out_insert_dropped    = out_dropped_r;
  assign out_found             = out_found_r;
  assign out_picked_number     = out_num_r;
  assign out_picked_first_tag  = out_t1_r;
  assign out_picked_second_tag = out_t2_r;

endmodule

// ----- rtl/reservation_station_select.sv -----
// Top level of the reservation station with oldest-first select.
//
//   channel   direction  handshake              payload
//   command   in         start / busy           in_kind, in_seq_number, tags, ready bits
//   result    out        out_strobe (no stall)  space, dropped, found, picked fields
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A command beat is taken at an edge where start is high and busy is low, and the
// table is then walked one entry per cycle: a wakeup, an unknown kind or a count of
// zero ends the walk at once, a select walks the entries in use, and the others stop
// at the first matching entry (or walk the entries in use on a miss).
// The result beat shows for one cycle once busy is low again; it cannot be stalled.
// Synchronous active-low reset clears the valid and scheduled marks and the walk state.
module reservation_station_select #(
  parameter int ENTRIES  = rss_pkg::RSS_ENTRIES,
  parameter int TAG_BITS = rss_pkg::RSS_TAG_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [rss_pkg::KIND_W-1:0]     in_kind,
  input  logic [rss_pkg::SEQ_W-1:0]      in_seq_number,
  input  logic [rss_pkg::PORT_TAG_W-1:0] in_first_tag,
  input  logic                           in_first_ready,
  input  logic [rss_pkg::PORT_TAG_W-1:0] in_second_tag,
  input  logic                           in_second_ready,
  input  logic [rss_pkg::PORT_TAG_W-1:0] in_broadcast_tag,
  output logic                           out_strobe,
  output logic                           out_space_available,
  output logic                           out_insert_dropped,
  output logic                           out_found,
  output logic [rss_pkg::SEQ_W-1:0]      out_picked_number,
  output logic [rss_pkg::PORT_TAG_W-1:0] out_picked_first_tag,
  output logic [rss_pkg::PORT_TAG_W-1:0] out_picked_second_tag,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rss_pkg::*;

  rss_cmd_t cmd;
  rss_sts_t sts;
  logic     cfg_we;

  // Configuration beats are taken whenever no command is in flight.
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  // The controller only sequences; all table state lives in the datapath.
  rss_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  rss_dp #(
    .ENTRIES  (ENTRIES),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_kind               (in_kind),
    .in_seq_number         (in_seq_number),
    .in_first_tag          (in_first_tag),
    .in_first_ready        (in_first_ready),
    .in_second_tag         (in_second_tag),
    .in_second_ready       (in_second_ready),
    .in_broadcast_tag      (in_broadcast_tag),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .out_strobe            (out_strobe),
    .out_space_available   (out_space_available),
    .out_insert_dropped    (out_insert_dropped),
    .out_found             (out_found),
    .out_picked_number     (out_picked_number),
    .out_picked_first_tag  (out_picked_first_tag),
    .out_picked_second_tag (out_picked_second_tag)
  );

endmodule

// ----- rtl/rss_checker.sv -----
// Port-level checker for the reservation station and its bind statement.
`include "reservation_station_select_macros.svh"

module rss_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_strobe,
  input logic                           out_space_available,
  input logic                           out_insert_dropped,
  input logic                           out_found,
  input logic [rss_pkg::SEQ_W-1:0]      out_picked_number,
  input logic [rss_pkg::PORT_TAG_W-1:0] out_picked_first_tag,
  input logic [rss_pkg::PORT_TAG_W-1:0] out_picked_second_tag
);

  // A taken command keeps the block busy in the following cycle.
  `RSS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy)

  // No result beat can follow directly after a command is taken.
  `RSS_ASSERT_NEXT(a_no_strobe_after_accept, clk, rst_n, start && !busy, !out_strobe)

  // A result beat appears only once the block has gone idle.
  `RSS_ASSERT_SAME(a_strobe_when_idle, clk, rst_n, out_strobe, !busy)

  // A dropped insert means the table had no free entry left.
  `RSS_ASSERT_SAME(a_drop_means_full, clk, rst_n,
                   out_strobe && out_insert_dropped, !out_space_available)

  // Without a pick, the picked fields read as zero.
  `RSS_ASSERT_SAME(a_no_pick_zero, clk, rst_n, out_strobe && !out_found,
                   out_picked_number == '0 && out_picked_first_tag == '0 && out_picked_second_tag == '0)

endmodule

bind reservation_station_select rss_checker u_rss_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the reservation station with oldest-first select.
module tb_top;
  import rss_pkg::*;

  // The run is stopped here if the block hangs. A correct run stays well inside
  // this limit, even with every item walking the whole table and the sender
  // idling most of the time.
  localparam int CYCLE_LIMIT = 400000;

  // Indexes past the two real registers. Writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

  // Register settings for the random phases. They include a count of zero,
  // a count above the table size and a single entry, and use both issue modes.
  localparam int PHASES = 8;
  localparam int PHASE_IN_USE [PHASES] = '{16, 16, 4, 1, 31, 0, 9, 16};
  localparam int PHASE_MODE   [PHASES] = '{1, 0, 1, 0, 1, 0, 0, 1};
  localparam int PHASE_ITEMS  [PHASES] = '{140, 140, 140, 140, 140, 40, 140, 140};

  // Random items are split in thirds: sender idles often, then very often,
  // then never.
  localparam int THIRD = 340;

  // Number of mismatch lines printed before the rest are only counted.
  localparam int REPORT_CAP = 40;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [SEQ_W-1:0]      seq_number;
    logic [PORT_TAG_W-1:0] first_tag;
    logic                  first_ready;
    logic [PORT_TAG_W-1:0] second_tag;
    logic                  second_ready;
    logic [PORT_TAG_W-1:0] broadcast_tag;
  } command_t;

  typedef struct packed {
    logic                  space_available;
    logic                  insert_dropped;
    logic                  found;
    logic [SEQ_W-1:0]      picked_number;
    logic [PORT_TAG_W-1:0] picked_first_tag;
    logic [PORT_TAG_W-1:0] picked_second_tag;
  } report_t;

  // The scoreboard keeps its own copy of the table and the two registers.
  // Each accepted command is applied to that copy, and the report it must
  // produce is queued. Each report seen on the outputs is checked against
  // the oldest queued one.
  class station_scoreboard;
    logic                  slot_valid  [RSS_ENTRIES];
    logic                  slot_issued [RSS_ENTRIES];
    logic [SEQ_W-1:0]      slot_number [RSS_ENTRIES];
    logic [PORT_TAG_W-1:0] slot_tag_a  [RSS_ENTRIES];
    logic                  slot_rdy_a  [RSS_ENTRIES];
    logic [PORT_TAG_W-1:0] slot_tag_b  [RSS_ENTRIES];
    logic                  slot_rdy_b  [RSS_ENTRIES];
    logic [CFG_DATA_W-1:0] in_use;
    logic                  out_of_order;
    report_t               pending_reports [$];
    int                    mismatches;
    int                    checked;
    int                    dropped_inserts;
    int                    issued_selects;

    function new();
      for (int i = 0; i < RSS_ENTRIES; i++) begin
        slot_valid[i]  = 1'b0;
        slot_issued[i] = 1'b0;
      end
      in_use          = ENTRIES_IN_USE_RST;
      out_of_order    = ISSUE_MODE_RST;
      mismatches      = 0;
      checked         = 0;
      dropped_inserts = 0;
      issued_selects  = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_ENTRIES_IN_USE) begin
        in_use = data;
      end else if (idx == CFG_ISSUE_MODE) begin
        out_of_order = data[0];
      end
    endfunction

    function void note_command(command_t c);
      int      n;
      int      slot;
      report_t r;
      n    = (in_use > RSS_ENTRIES) ? RSS_ENTRIES : int'(in_use);
      slot = -1;
      r    = '0;
      case (c.kind)
        KIND_INSERT: begin
          for (int i = 0; i < n; i++)
            if (slot < 0 && !slot_valid[i]) slot = i;
          if (slot < 0) begin
            r.insert_dropped = 1'b1;
            dropped_inserts++;
          end else begin
            slot_valid[slot]  = 1'b1;
            slot_issued[slot] = 1'b0;
            slot_number[slot] = c.seq_number;
            slot_tag_a[slot]  = c.first_tag;
            slot_rdy_a[slot]  = c.first_ready;
            slot_tag_b[slot]  = c.second_tag;
            slot_rdy_b[slot]  = c.second_ready;
          end
        end
        KIND_WAKEUP: begin
          for (int i = 0; i < n; i++) begin
            if (slot_valid[i] && slot_tag_a[i] == c.broadcast_tag) slot_rdy_a[i] = 1'b1;
            if (slot_valid[i] && slot_tag_b[i] == c.broadcast_tag) slot_rdy_b[i] = 1'b1;
          end
        end
        KIND_SELECT: begin
          // Oldest unscheduled entry; out-of-order mode only looks at ready
          // ones, in-order mode rejects the oldest if it is not ready.
          for (int i = 0; i < n; i++) begin
            if (slot_valid[i] && !slot_issued[i] &&
                (!out_of_order || (slot_rdy_a[i] && slot_rdy_b[i]))) begin
              if (slot < 0) slot = i;
              else if (slot_number[i] < slot_number[slot]) slot = i;
            end
          end
          if (slot >= 0 && !(slot_rdy_a[slot] && slot_rdy_b[slot])) slot = -1;
          if (slot >= 0) begin
            r.found             = 1'b1;
            r.picked_number     = slot_number[slot];
            r.picked_first_tag  = slot_tag_a[slot];
            r.picked_second_tag = slot_tag_b[slot];
            issued_selects++;
          end
        end
        KIND_SCHEDULE: begin
          for (int i = 0; i < n; i++)
            if (slot < 0 && slot_valid[i] && slot_number[i] == c.seq_number) slot = i;
          if (slot >= 0) slot_issued[slot] = 1'b1;
        end
        KIND_REMOVE: begin
          for (int i = 0; i < n; i++)
            if (slot < 0 && slot_valid[i] && slot_issued[i] &&
                slot_number[i] == c.seq_number) slot = i;
          if (slot >= 0) begin
            slot_valid[slot]  = 1'b0;
            slot_issued[slot] = 1'b0;
          end
        end
        default: ;
      endcase
      for (int i = 0; i < n; i++)
        if (!slot_valid[i]) r.space_available = 1'b1;
      pending_reports.push_back(r);
    endfunction

    function void compare_field(string field, logic [SEQ_W-1:0] want, logic [SEQ_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      checked++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: result beat expected none, got number %0h found %b",
                   $time, got.picked_number, got.found);
      end else begin
        want = pending_reports.pop_front();
        compare_field("space_available", SEQ_W'(want.space_available),
                      SEQ_W'(got.space_available));
        compare_field("insert_dropped", SEQ_W'(want.insert_dropped),
                      SEQ_W'(got.insert_dropped));
        compare_field("found", SEQ_W'(want.found), SEQ_W'(got.found));
        compare_field("picked_number", want.picked_number, got.picked_number);
        compare_field("picked_first_tag", SEQ_W'(want.picked_first_tag),
                      SEQ_W'(got.picked_first_tag));
        compare_field("picked_second_tag", SEQ_W'(want.picked_second_tag),
                      SEQ_W'(got.picked_second_tag));
      end
    endfunction
  endclass

  // Block ports. Every input starts at a known value.
  logic                  clk;
  logic                  rst_n            = 1'b0;
  logic                  start            = 1'b0;
  logic                  busy;
  logic [KIND_W-1:0]     in_kind          = '0;
  logic [SEQ_W-1:0]      in_seq_number    = '0;
  logic [PORT_TAG_W-1:0] in_first_tag     = '0;
  logic                  in_first_ready   = 1'b0;
  logic [PORT_TAG_W-1:0] in_second_tag    = '0;
  logic                  in_second_ready  = 1'b0;
  logic [PORT_TAG_W-1:0] in_broadcast_tag = '0;
  logic                  out_strobe;
  logic                  out_space_available;
  logic                  out_insert_dropped;
  logic                  out_found;
  logic [SEQ_W-1:0]      out_picked_number;
  logic [PORT_TAG_W-1:0] out_picked_first_tag;
  logic [PORT_TAG_W-1:0] out_picked_second_tag;
  logic                  cfg_valid        = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;

  station_scoreboard sb;
  report_t           seen_report;
  int                cycle_count      = 0;
  int                commands_sent    = 0;
  int                directed_sent    = 0;
  int                random_sent      = 0;
  int                settings_applied = 0;

  // Generator state: recently inserted numbers and tags, so that wakeups,
  // schedules and removes mostly hit live entries instead of missing.
  logic [SEQ_W-1:0]      next_number    = 32'h0000_0100;
  logic [SEQ_W-1:0]      recent_numbers [$];
  logic [PORT_TAG_W-1:0] recent_tags    [$];
  logic [SEQ_W-1:0]      queued_remove  = '0;
  logic                  remove_queued  = 1'b0;

  reservation_station_select uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. A hung handshake or a missing result ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL reservation_station_select");
      $finish;
    end
  end

  // Results are sampled in the middle of their one-cycle window, well away
  // from the edge where the block updates them.
  always @(negedge clk) begin
    if (rst_n && out_strobe) begin
      seen_report.space_available   = out_space_available;
      seen_report.insert_dropped    = out_insert_dropped;
      seen_report.found             = out_found;
      seen_report.picked_number     = out_picked_number;
      seen_report.picked_first_tag  = out_picked_first_tag;
      seen_report.picked_second_tag = out_picked_second_tag;
      sb.check_report(seen_report);
    end
  end

  // Drives one command beat. The task is entered just after a rising edge.
  // Busy is looked at on the falling edge: if it is low there, the next
  // rising edge takes the beat, so the command is handed to the scoreboard
  // before its result can possibly show up. The task returns on the edge
  // that took the beat, leaving start high; the caller either drives the
  // next beat or lowers start, never both in one step.
  task automatic send_command(input command_t c);
    start            <= 1'b1;
    in_kind          <= c.kind;
    in_seq_number    <= c.seq_number;
    in_first_tag     <= c.first_tag;
    in_first_ready   <= c.first_ready;
    in_second_tag    <= c.second_tag;
    in_second_ready  <= c.second_ready;
    in_broadcast_tag <= c.broadcast_tag;
    @(negedge clk);
    while (busy) @(negedge clk);
    sb.note_command(c);
    commands_sent++;
    @(posedge clk);
  endtask

  // Random sender gaps: each cycle the sender holds off with the given
  // percentage, so gaps of any length land anywhere in the block's walk.
  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Holds the sender off until every queued result has come back and the
  // block reports idle. Start is lowered first so nothing new is taken.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk);
    while (sb.pending_reports.size() != 0 || busy);
  endtask

  // One configuration beat. Valid stays high on return so that back-to-back
  // writes never lower and raise it in the same step.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    sb.write_register(idx, data);
    @(posedge clk);
  endtask

  // Registers change only on an idle block. Each setting also carries a
  // stray write to an unused index, which must leave both registers alone.
  // The mode write carries random upper bits, since only bit 0 counts.
  task automatic configure(input logic [CFG_DATA_W-1:0] count, input logic mode);
    drain();
    write_register($urandom_range(1) ? CFG_UNUSED_HI : CFG_UNUSED_LO,
                   CFG_DATA_W'($urandom));
    write_register(CFG_ENTRIES_IN_USE, count);
    write_register(CFG_ISSUE_MODE, {4'($urandom), mode});
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // Directed command with explicit fields.
  task automatic issue(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] seq,
                       input logic [PORT_TAG_W-1:0] t1, input logic r1,
                       input logic [PORT_TAG_W-1:0] t2, input logic r2,
                       input logic [PORT_TAG_W-1:0] bt);
    idle_gap(27);
    send_command('{kind, seq, t1, r1, t2, r2, bt});
    directed_sent++;
  endtask

  // Tags come mostly from a small pool so that wakeups find matches, with
  // the extremes and the full range mixed in.
  function automatic logic [PORT_TAG_W-1:0] pick_tag();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return PORT_TAG_W'($urandom_range(15));
    if (roll < 80) return roll[0] ? '1 : '0;
    return PORT_TAG_W'($urandom);
  endfunction

  function automatic logic [SEQ_W-1:0] pick_recent();
    if (recent_numbers.size() == 0 || $urandom_range(99) < 15) return $urandom;
    return recent_numbers[$urandom_range(recent_numbers.size() - 1)];
  endfunction

  // Builds the next random command. Fields unused by the kind carry random
  // noise. Most traffic forms real instruction lifetimes: insert, wake the
  // sources, select, schedule, and often a remove right after the schedule.
  function automatic command_t next_random_command();
    command_t c;
    int       roll;
    int       pick;
    c.kind          = KIND_SELECT;
    c.seq_number    = $urandom;
    c.first_tag     = PORT_TAG_W'($urandom);
    c.first_ready   = 1'($urandom);
    c.second_tag    = PORT_TAG_W'($urandom);
    c.second_ready  = 1'($urandom);
    c.broadcast_tag = PORT_TAG_W'($urandom);
    roll            = $urandom_range(99);
    if (remove_queued) begin
      remove_queued = 1'b0;
      c.kind        = KIND_REMOVE;
      c.seq_number  = queued_remove;
    end else if (roll < 28) begin
      // Numbers mostly climb; a step of zero gives an age tie.
      c.kind = KIND_INSERT;
      pick   = $urandom_range(99);
      if (pick < 80) begin
        next_number  = next_number + SEQ_W'($urandom_range(3));
        c.seq_number = next_number;
      end else if (pick < 90) begin
        c.seq_number = $urandom;
      end else if (pick < 95) begin
        c.seq_number = '0;
      end else begin
        c.seq_number = '1;
      end
      c.first_tag    = pick_tag();
      c.second_tag   = pick_tag();
      c.first_ready  = ($urandom_range(99) < 35);
      c.second_ready = ($urandom_range(99) < 35);
      recent_numbers.push_back(c.seq_number);
      recent_tags.push_back(c.first_tag);
      recent_tags.push_back(c.second_tag);
      if (recent_numbers.size() > 24) void'(recent_numbers.pop_front());
      while (recent_tags.size() > 32) void'(recent_tags.pop_front());
    end else if (roll < 48) begin
      c.kind = KIND_WAKEUP;
      if (recent_tags.size() != 0 && $urandom_range(99) < 80)
        c.broadcast_tag = recent_tags[$urandom_range(recent_tags.size() - 1)];
      else
        c.broadcast_tag = pick_tag();
    end else if (roll < 70) begin
      c.kind = KIND_SELECT;
    end else if (roll < 86) begin
      c.kind       = KIND_SCHEDULE;
      c.seq_number = pick_recent();
      if ($urandom_range(1)) begin
        remove_queued = 1'b1;
        queued_remove = c.seq_number;
      end
    end else if (roll < 96) begin
      c.kind       = KIND_REMOVE;
      c.seq_number = pick_recent();
    end else begin
      // Codes past remove do nothing but report space.
      c.kind = KIND_W'($urandom_range(5, 7));
    end
    return c;
  endfunction

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first at the reset settings: sixteen entries and
    // out-of-order issue. Select on an empty table finds nothing.
    issue(KIND_SELECT, '0, '0, 1'b0, '0, 1'b0, '0);
    // Largest number with nothing ready, then two entries tied at number
    // zero; the tie must go to the lower entry.
    issue(KIND_INSERT, '1, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h33);
    issue(KIND_INSERT, '0, 8'h00, 1'b1, 8'hFF, 1'b1, 8'hCC);
    issue(KIND_INSERT, '0, 8'h5A, 1'b1, 8'hA5, 1'b1, 8'h0F);
    issue(KIND_SELECT, 32'h1234_5678, 8'h77, 1'b1, 8'h88, 1'b0, 8'hF0);
    // Wake both sources of the oldest-numbered-last entry using the extreme
    // tags.
    issue(KIND_WAKEUP, 32'hFFFF_0000, 8'h12, 1'b1, 8'h34, 1'b1, 8'hFF);
    issue(KIND_WAKEUP, 32'h0000_FFFF, 8'hED, 1'b0, 8'hCB, 1'b0, 8'h00);
    // Scheduling the same number twice marks the same lowest entry again.
    issue(KIND_SCHEDULE, '0, '0, 1'b0, '0, 1'b0, '0);
    issue(KIND_SCHEDULE, '0, '1, 1'b1, '1, 1'b1, '1);
    issue(KIND_SELECT, '0, '0, 1'b0, '0, 1'b0, '0);
    // The first remove frees the scheduled entry; the second finds only an
    // unscheduled one and must change nothing; then two misses.
    issue(KIND_REMOVE, '0, '0, 1'b0, '0, 1'b0, '0);
    issue(KIND_REMOVE, '0, '0, 1'b0, '0, 1'b0, '0);
    issue(KIND_REMOVE, 32'h1234_5678, '0, 1'b0, '0, 1'b0, '0);
    issue(KIND_SCHEDULE, 32'h0BAD_F00D, '0, 1'b0, '0, 1'b0, '0);
    // Undefined kinds.
    issue(3'd5, 32'hAAAA_AAAA, 8'hAA, 1'b1, 8'h55, 1'b0, 8'hAA);
    issue(3'd7, 32'h5555_5555, 8'h55, 1'b0, 8'hAA, 1'b1, 8'h55);
    // Refill the freed entry with a younger, not yet ready instruction.
    issue(KIND_INSERT, 32'd7, 8'h11, 1'b0, 8'h22, 1'b1, 8'h00);

    // In-order issue: once the ready oldest is scheduled, the oldest left is
    // not ready, so nothing issues even though a younger entry is ready.
    configure(5'd16, 1'b0);
    issue(KIND_SELECT, '0, '0, 1'b0, '0, 1'b0, '0);
    issue(KIND_SCHEDULE, '0, '0, 1'b0, '0, 1'b0, '0);
    issue(KIND_SELECT, '0, '0, 1'b0, '0, 1'b0, '0);
    issue(KIND_WAKEUP, '0, '0, 1'b0, '0, 1'b0, 8'h11);
    issue(KIND_SELECT, '0, '0, 1'b0, '0, 1'b0, '0);

    // No entries in use: never any space, every insert dropped.
    configure(5'd0, 1'b1);
    issue(KIND_INSERT, 32'd99, 8'h01, 1'b1, 8'h02, 1'b1, 8'h00);
    issue(KIND_SELECT, '0, '0, 1'b0, '0, 1'b0, '0);
    // A single entry, already occupied: the table is full.
    configure(5'd1, 1'b1);
    issue(KIND_INSERT, 32'd100, 8'h03, 1'b1, 8'h04, 1'b1, 8'h00);
    // A count above the table size acts as the full table, and the hidden
    // entries come back with their contents.
    configure(5'd31, 1'b1);
    issue(KIND_SELECT, '0, '0, 1'b0, '0, 1'b0, '0);

    // Random part, one register setting per phase.
    for (int p = 0; p < PHASES; p++) begin
      configure(CFG_DATA_W'(PHASE_IN_USE[p]), 1'(PHASE_MODE[p]));
      for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
        idle_gap(random_sent < THIRD ? 27 : (random_sent < 2 * THIRD ? 70 : 0));
        // Once in mid-phase, let the pipeline run completely dry.
        if (k == PHASE_ITEMS[p] / 2 && p == 3) drain();
        send_command(next_random_command());
        random_sent++;
      end
    end

    // Wait for the last result, then a few more cycles in case the block
    // sends a stray beat.
    drain();
    repeat (24) @(posedge clk);

    $display("Ran %0d commands (%0d directed, %0d random) over %0d register settings.",
             commands_sent, directed_sent, random_sent, settings_applied);
    $display("Checked %0d results: %0d inserts dropped, %0d selects issued.",
             sb.checked, sb.dropped_inserts, sb.issued_selects);
    if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
      $display("PASS reservation_station_select");
    end else begin
      $display("FAIL reservation_station_select");
    end
    $finish;
  end

endmodule
